/* sv/assert_macros.svh */
// assertion macros shared by the stepper ramp controller rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SRPJ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SRPJ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/srpj_pkg.sv */
// shared types and constants of the stepper ramp position/jog controller
// no dependencies; used by the interfaces, the arithmetic units and the top level
package srpj_pkg;

    localparam int STEP_UNITS_DEF    = 10;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int MODE_W     = 3;
    localparam int VALUE_W    = 32;
    localparam int VEL_W      = 32;
    localparam int MAG_W      = 31;
    localparam int LIM_W      = 17;
    localparam int AGE_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int CHUNK_W    = 16;
    localparam int ROOT_W     = 31;
    localparam int SQ_IN_W    = 2 * ROOT_W;

    localparam logic [LIM_W-1:0] LIM_ONE       = 17'h10000;
    localparam logic [AGE_W-1:0] REL_TICKS_RST = 16'd100;

    // item modes
    localparam logic [MODE_W-1:0] MODE_TICK     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GOTO     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_JOG_FWD  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_JOG_BACK = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SET_POS  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_STOP     = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIM_FWD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIM_BACK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_TICKS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIST,
        ST_RATE_GO,
        ST_MUL,
        ST_SQRT,
        ST_VEL,
        ST_CAP,
        ST_CLAMP,
        ST_POS,
        ST_STEP,
        ST_SNAP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic done;
        logic sat;
    } t_mul_stat;

endpackage

/* sv/srpj_in_if.sv */
// input channel of the stepper ramp controller: valid/ready plus one item
// depends on srpj_pkg for field widths
interface srpj_in_if;
    logic                              valid;
    logic                              ready;
    logic [srpj_pkg::MODE_W-1:0]       mode;
    logic signed [srpj_pkg::VALUE_W-1:0] value;
    logic                              allow_forward;
    logic                              allow_backward;

    modport source (output valid, mode, value, allow_forward, allow_backward, input ready);
    modport sink   (input valid, mode, value, allow_forward, allow_backward, output ready);
endinterface

/* sv/srpj_out_if.sv */
// result channel of the stepper ramp controller: valid/ready plus one status beat
// depends on srpj_pkg for field widths
interface srpj_out_if;
    logic                                valid;
    logic                                ready;
    logic                                step_active;
    logic                                direction_forward;
    logic                                moving;
    logic signed [srpj_pkg::VALUE_W-1:0] position_now;

    modport source (output valid, step_active, direction_forward, moving, position_now,
                    input ready);
    modport sink   (input valid, step_active, direction_forward, moving, position_now,
                    output ready);
endinterface

/* sv/stepper_ramp_position_jog_controller.sv */
// top level of the stepper ramp generator: sequencer, motion state, config registers
// depends on srpj_pkg, srpj_in_if, srpj_out_if, srpj_mul, srpj_isqrt, assert_macros.svh
//
//  channel   dir   handshake          payload
//  i_in      in    valid/ready        mode, value, allow_forward, allow_backward
//  o_out     out   valid/ready        step_active, direction_forward, moving, position_now
//  i_cfg_*   in    write enable only  register index, write data
//
// one item at a time; i_in.ready is high only while the sequencer is idle
// commands, pulse-ending ticks and disabled ticks go from execution straight to the output
// a position-mode tick whose product saturates skips the root unit
// position-mode ticks off target run the chunk multiplier and the 31-step root unit
// the result sits in an output register, so the next item is taken while it waits
// reset is synchronous and active low; it restores the control, motion and config registers
`include "assert_macros.svh"

module stepper_ramp_position_jog_controller #(
    parameter int STEP_UNITS    = srpj_pkg::STEP_UNITS_DEF,
    parameter int FRACTION_BITS = srpj_pkg::FRACTION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [srpj_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [srpj_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    srpj_in_if.sink                           i_in,
    srpj_out_if.source                        o_out
);
    localparam int POS_W  = 32 + FRACTION_BITS;
    localparam int DW     = POS_W + 1;
    localparam int DIST_W = POS_W;
    localparam int VW     = srpj_pkg::VEL_W + 2;
    localparam int MW     = srpj_pkg::MAG_W;

    localparam logic signed [DW-1:0] HALF_FIX = DW'(STEP_UNITS / 2) <<< FRACTION_BITS;
    localparam logic signed [DW-1:0] FULL_FIX = DW'(STEP_UNITS) <<< FRACTION_BITS;
    localparam logic signed [DW-1:0] NEG_HALF = -HALF_FIX;
    localparam logic signed [DW-1:0] NEG_FULL = -FULL_FIX;

    // configuration
    logic [MW-1:0]                   r_max_vel;
    logic [MW-1:0]                   r_accel;
    logic [srpj_pkg::LIM_W-1:0]      r_lim_fwd;
    logic [srpj_pkg::LIM_W-1:0]      r_lim_back;
    logic [srpj_pkg::AGE_W-1:0]      r_rel_ticks;
    logic                            r_enabled;

    // motion state
    srpj_pkg::t_state                r_state, n_state;
    logic signed [POS_W-1:0]         r_cmd, n_cmd;
    logic signed [31:0]              r_motor, n_motor;
    logic signed [31:0]              r_target, n_target;
    logic signed [srpj_pkg::VEL_W-1:0] r_vel, n_vel;
    logic                            r_in_pos, n_in_pos;
    logic                            r_jog_fwd, n_jog_fwd;
    logic                            r_jog_back, n_jog_back;
    logic [srpj_pkg::AGE_W-1:0]      r_jog_age, n_jog_age;
    logic                            r_pulse, n_pulse;
    logic                            r_last_dir, n_last_dir;

    // latched item and work registers
    logic [srpj_pkg::MODE_W-1:0]     r_mode;
    logic signed [31:0]              r_value;
    logic                            r_allow_fwd;
    logic                            r_allow_back;
    logic [DIST_W-1:0]               r_dist, n_dist;
    logic                            r_gt, n_gt;
    logic                            r_lt, n_lt;
    logic [MW-1:0]                   r_vd, n_vd;
    logic signed [VW-1:0]            r_vnew, n_vnew;
    logic [MW-1:0]                   r_cap, n_cap;
    logic                            r_step, n_step;
    logic                            r_snap_fwd, n_snap_fwd;

    // result register
    logic                            r_out_valid, n_out_valid;
    logic                            r_o_step;
    logic                            r_o_dir;
    logic                            r_o_moving;
    logic signed [31:0]              r_o_pos;

    // sequencer outputs
    logic                            s_in_ready;
    logic                            s_accept;
    logic                            s_mul_start;
    logic                            s_sqrt_start;
    logic                            s_out_load;

    // arithmetic
    srpj_pkg::t_mul_stat             s_mul_stat;
    logic [srpj_pkg::SQ_IN_W-1:0]    s_mul_prod;
    logic                            s_sqrt_done;
    logic [srpj_pkg::ROOT_W-1:0]     s_root;
    logic signed [DW-1:0]            s_cmd_ext;
    logic signed [DW-1:0]            s_tgt_diff;
    logic signed [DW-1:0]            s_mot_diff;
    logic signed [VW-1:0]            s_v;
    logic signed [VW-1:0]            s_a;
    logic signed [VW-1:0]            s_vd;
    logic signed [VW-1:0]            s_vm;
    logic signed [VW-1:0]            s_cap;
    logic signed [VW-1:0]            s_up;
    logic signed [VW-1:0]            s_dn;
    logic [srpj_pkg::LIM_W-1:0]      s_lim_sel;
    logic [srpj_pkg::LIM_W-1:0]      s_lim;
    logic [47:0]                     s_cap_prod;

    assign s_cmd_ext  = {r_cmd[POS_W-1], r_cmd};
    assign s_tgt_diff = {r_target[31], r_target, {FRACTION_BITS{1'b0}}} - s_cmd_ext;
    assign s_mot_diff = s_cmd_ext - {r_motor[31], r_motor, {FRACTION_BITS{1'b0}}};

    assign s_v  = {{2{r_vel[srpj_pkg::VEL_W-1]}}, r_vel};
    assign s_a  = {3'b000, r_accel};
    assign s_vd = {3'b000, r_vd};
    assign s_vm = {3'b000, r_max_vel};
    assign s_cap = {3'b000, r_cap};
    assign s_up = s_v + s_a;
    assign s_dn = s_v - s_a;

    // soft limit for the direction of the ramped velocity, values above one act as one
    assign s_lim_sel  = (r_vnew > 0) ? r_lim_fwd : r_lim_back;
    assign s_lim      = (s_lim_sel > srpj_pkg::LIM_ONE) ? srpj_pkg::LIM_ONE : s_lim_sel;
    assign s_cap_prod = {31'b0, s_lim} * {17'b0, r_max_vel};

    srpj_mul #(
        .A_W (DIST_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_mul_start),
        .i_a     (r_dist),
        .i_b     (r_accel),
        .o_stat  (s_mul_stat),
        .o_prod  (s_mul_prod)
    );

    srpj_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_sqrt_start),
        .i_n     (s_mul_prod),
        .o_done  (s_sqrt_done),
        .o_root  (s_root)
    );

    // sequencer outputs
    always_comb begin
        s_in_ready   = (r_state == srpj_pkg::ST_IDLE);
        s_mul_start  = (r_state == srpj_pkg::ST_RATE_GO) && r_in_pos && (r_gt || r_lt);
        s_sqrt_start = (r_state == srpj_pkg::ST_MUL) && s_mul_stat.done && !s_mul_stat.sat;
        s_out_load   = (r_state == srpj_pkg::ST_OUT) && (!r_out_valid || o_out.ready);
    end

    assign s_accept = i_in.valid && s_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srpj_pkg::ST_IDLE: begin
                if (s_accept) begin
                    n_state = srpj_pkg::ST_EXEC;
                end
            end
            srpj_pkg::ST_EXEC: begin
                if (r_mode == srpj_pkg::MODE_TICK && !r_pulse && r_enabled) begin
                    n_state = srpj_pkg::ST_DIST;
                end else begin
                    n_state = srpj_pkg::ST_OUT;
                end
            end
            srpj_pkg::ST_DIST:    n_state = srpj_pkg::ST_RATE_GO;
            srpj_pkg::ST_RATE_GO: n_state = s_mul_start ? srpj_pkg::ST_MUL : srpj_pkg::ST_VEL;
            srpj_pkg::ST_MUL: begin
                if (s_mul_stat.done) begin
                    n_state = s_mul_stat.sat ? srpj_pkg::ST_VEL : srpj_pkg::ST_SQRT;
                end
            end
            srpj_pkg::ST_SQRT: begin
                if (s_sqrt_done) begin
                    n_state = srpj_pkg::ST_VEL;
                end
            end
            srpj_pkg::ST_VEL:   n_state = srpj_pkg::ST_CAP;
            srpj_pkg::ST_CAP:   n_state = srpj_pkg::ST_CLAMP;
            srpj_pkg::ST_CLAMP: n_state = srpj_pkg::ST_POS;
            srpj_pkg::ST_POS:   n_state = srpj_pkg::ST_STEP;
            srpj_pkg::ST_STEP: begin
                if ((s_mot_diff > HALF_FIX && r_allow_fwd) ||
                    (s_mot_diff < NEG_HALF && r_allow_back)) begin
                    n_state = srpj_pkg::ST_SNAP;
                end else begin
                    n_state = srpj_pkg::ST_OUT;
                end
            end
            srpj_pkg::ST_SNAP: n_state = srpj_pkg::ST_OUT;
            srpj_pkg::ST_OUT: begin
                if (s_out_load) begin
                    n_state = srpj_pkg::ST_IDLE;
                end
            end
            default: n_state = srpj_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_cmd       = r_cmd;
        n_motor     = r_motor;
        n_target    = r_target;
        n_vel       = r_vel;
        n_in_pos    = r_in_pos;
        n_jog_fwd   = r_jog_fwd;
        n_jog_back  = r_jog_back;
        n_jog_age   = r_jog_age;
        n_pulse     = r_pulse;
        n_last_dir  = r_last_dir;
        n_dist      = r_dist;
        n_gt        = r_gt;
        n_lt        = r_lt;
        n_vd        = r_vd;
        n_vnew      = r_vnew;
        n_cap       = r_cap;
        n_step      = r_step;
        n_snap_fwd  = r_snap_fwd;
        n_out_valid = r_out_valid && !o_out.ready;
        if (s_out_load) begin
            n_out_valid = 1'b1;
        end

        unique case (r_state)
            srpj_pkg::ST_EXEC: begin
                n_step = r_pulse;
                unique case (r_mode)
                    srpj_pkg::MODE_TICK: begin
                        if (r_jog_age != '1) begin
                            n_jog_age = r_jog_age + 1'b1;
                        end
                        n_step  = 1'b0;
                        n_pulse = 1'b0;
                    end
                    srpj_pkg::MODE_GOTO: begin
                        n_target = r_value;
                        n_in_pos = 1'b1;
                    end
                    srpj_pkg::MODE_JOG_FWD: begin
                        n_in_pos   = 1'b0;
                        n_jog_fwd  = 1'b1;
                        n_jog_back = 1'b0;
                        n_jog_age  = '0;
                    end
                    srpj_pkg::MODE_JOG_BACK: begin
                        n_in_pos   = 1'b0;
                        n_jog_back = 1'b1;
                        n_jog_fwd  = 1'b0;
                        n_jog_age  = '0;
                    end
                    srpj_pkg::MODE_SET_POS: begin
                        n_cmd    = {r_value, {FRACTION_BITS{1'b0}}};
                        n_target = r_value;
                        n_motor  = r_value;
                        n_vel    = '0;
                    end
                    srpj_pkg::MODE_STOP: begin
                        n_jog_fwd  = 1'b0;
                        n_jog_back = 1'b0;
                        n_target   = r_motor;
                    end
                    default: ;
                endcase
            end
            srpj_pkg::ST_DIST: begin
                n_gt   = !s_tgt_diff[DW-1] && (s_tgt_diff != '0);
                n_lt   = s_tgt_diff[DW-1];
                n_dist = s_tgt_diff[DW-1] ? DIST_W'(-s_tgt_diff) : DIST_W'(s_tgt_diff);
            end
            srpj_pkg::ST_MUL: begin
                // a product of 2^62 or more limits to the velocity ceiling
                if (s_mul_stat.done && s_mul_stat.sat) begin
                    n_vd = r_max_vel;
                end
            end
            srpj_pkg::ST_SQRT: begin
                if (s_sqrt_done) begin
                    n_vd = (s_root < r_max_vel) ? s_root : r_max_vel;
                end
            end
            srpj_pkg::ST_VEL: begin
                n_vnew = s_v;
                if (r_in_pos) begin
                    if (r_gt) begin
                        n_vnew = (s_up < s_vd) ? s_up : s_vd;
                    end else if (r_lt) begin
                        n_vnew = (s_dn > -s_vd) ? s_dn : -s_vd;
                    end
                end else if (r_jog_fwd || r_jog_back) begin
                    if (r_jog_fwd) begin
                        n_vnew = (s_up < s_vm) ? s_up : s_vm;
                    end else begin
                        n_vnew = (s_dn > -s_vm) ? s_dn : -s_vm;
                    end
                    // jog releases itself once it has aged out
                    if (r_jog_age >= r_rel_ticks) begin
                        n_jog_fwd  = 1'b0;
                        n_jog_back = 1'b0;
                        n_target   = r_motor;
                    end
                end else if (s_v > 0) begin
                    n_vnew = (s_dn > 0) ? s_dn : '0;
                end else if (s_v < 0) begin
                    n_vnew = (s_up < 0) ? s_up : '0;
                end
            end
            srpj_pkg::ST_CAP: begin
                n_cap = s_cap_prod[MW+15:16];
            end
            srpj_pkg::ST_CLAMP: begin
                n_vel = r_vnew[srpj_pkg::VEL_W-1:0];
                if (r_vnew > 0) begin
                    if (r_vnew > s_cap) begin
                        n_vel = s_cap[srpj_pkg::VEL_W-1:0];
                    end
                    if (!r_allow_fwd) begin
                        n_vel = '0;
                    end
                end else if (r_vnew < 0) begin
                    if (r_vnew < -s_cap) begin
                        n_vel = -s_cap[srpj_pkg::VEL_W-1:0];
                    end
                    if (!r_allow_back) begin
                        n_vel = '0;
                    end
                end
            end
            srpj_pkg::ST_POS: begin
                n_cmd = r_cmd + {{FRACTION_BITS{r_vel[srpj_pkg::VEL_W-1]}}, r_vel};
            end
            srpj_pkg::ST_STEP: begin
                n_step = 1'b0;
                if (s_mot_diff > HALF_FIX && r_allow_fwd) begin
                    n_pulse    = 1'b1;
                    n_last_dir = 1'b1;
                    n_motor    = r_motor + 32'(STEP_UNITS);
                    n_step     = 1'b1;
                    n_snap_fwd = 1'b1;
                end else if (s_mot_diff < NEG_HALF && r_allow_back) begin
                    n_pulse    = 1'b1;
                    n_last_dir = 1'b0;
                    n_motor    = r_motor - 32'(STEP_UNITS);
                    n_step     = 1'b1;
                    n_snap_fwd = 1'b0;
                end
            end
            srpj_pkg::ST_SNAP: begin
                // still more than a full step ahead of the motor: pull back onto it
                if (r_snap_fwd ? (s_mot_diff > FULL_FIX) : (s_mot_diff < NEG_FULL)) begin
                    n_cmd = {r_motor, {FRACTION_BITS{1'b0}}};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srpj_pkg::ST_IDLE;
            r_cmd       <= '0;
            r_motor     <= '0;
            r_target    <= '0;
            r_vel       <= '0;
            r_in_pos    <= 1'b0;
            r_jog_fwd   <= 1'b0;
            r_jog_back  <= 1'b0;
            r_jog_age   <= '0;
            r_pulse     <= 1'b0;
            r_last_dir  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmd       <= n_cmd;
            r_motor     <= n_motor;
            r_target    <= n_target;
            r_vel       <= n_vel;
            r_in_pos    <= n_in_pos;
            r_jog_fwd   <= n_jog_fwd;
            r_jog_back  <= n_jog_back;
            r_jog_age   <= n_jog_age;
            r_pulse     <= n_pulse;
            r_last_dir  <= n_last_dir;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_mode       <= i_in.mode;
            r_value      <= i_in.value;
            r_allow_fwd  <= i_in.allow_forward;
            r_allow_back <= i_in.allow_backward;
        end
        r_dist     <= n_dist;
        r_gt       <= n_gt;
        r_lt       <= n_lt;
        r_vd       <= n_vd;
        r_vnew     <= n_vnew;
        r_cap      <= n_cap;
        r_step     <= n_step;
        r_snap_fwd <= n_snap_fwd;
        if (s_out_load) begin
            r_o_step   <= r_step;
            r_o_dir    <= r_last_dir;
            r_o_moving <= (r_vel != '0);
            r_o_pos    <= r_cmd[POS_W-1:FRACTION_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_vel   <= '0;
            r_accel     <= '0;
            r_lim_fwd   <= srpj_pkg::LIM_ONE;
            r_lim_back  <= srpj_pkg::LIM_ONE;
            r_rel_ticks <= srpj_pkg::REL_TICKS_RST;
            r_enabled   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                srpj_pkg::CFG_MAX_VEL:   r_max_vel   <= i_cfg_data[MW-1:0];
                srpj_pkg::CFG_ACCEL:     r_accel     <= i_cfg_data[MW-1:0];
                srpj_pkg::CFG_LIM_FWD:   r_lim_fwd   <= i_cfg_data[srpj_pkg::LIM_W-1:0];
                srpj_pkg::CFG_LIM_BACK:  r_lim_back  <= i_cfg_data[srpj_pkg::LIM_W-1:0];
                srpj_pkg::CFG_REL_TICKS: r_rel_ticks <= i_cfg_data[srpj_pkg::AGE_W-1:0];
                srpj_pkg::CFG_ENABLED:   r_enabled   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign i_in.ready              = s_in_ready;
    assign o_out.valid             = r_out_valid;
    assign o_out.step_active       = r_o_step;
    assign o_out.direction_forward = r_o_dir;
    assign o_out.moving            = r_o_moving;
    assign o_out.position_now      = r_o_pos;

    `SRPJ_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, i_in.valid && i_in.ready, r_state == srpj_pkg::ST_EXEC, "accepted beat did not enter execution")
    `SRPJ_ASSERT_SAME(a_mul_done_state, i_clk, i_rst_n, s_mul_stat.done, r_state == srpj_pkg::ST_MUL, "multiplier finished outside its wait state")
    `SRPJ_ASSERT_SAME(a_sqrt_done_state, i_clk, i_rst_n, s_sqrt_done, r_state == srpj_pkg::ST_SQRT, "root unit finished outside its wait state")
    `SRPJ_ASSERT_NEXT(a_out_wait, i_clk, i_rst_n, r_state == srpj_pkg::ST_OUT && r_out_valid && !o_out.ready, r_state == srpj_pkg::ST_OUT && r_out_valid, "result overwrote an untaken beat")
    `SRPJ_ASSERT_SAME(a_snap_pulse, i_clk, i_rst_n, r_state == srpj_pkg::ST_SNAP, r_pulse && r_step, "step check without a pending pulse")

endmodule

/* sv/srpj_mul.sv */
// chunk-serial multiplier: distance times acceleration, 16 bits of distance per cycle
// flags products of 2^62 and above; depends on srpj_pkg
module srpj_mul #(
    parameter int A_W = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [A_W-1:0]                i_a,
    input  logic [srpj_pkg::MAG_W-1:0]    i_b,
    output srpj_pkg::t_mul_stat           o_stat,
    output logic [srpj_pkg::SQ_IN_W-1:0]  o_prod
);
    localparam int CW    = srpj_pkg::CHUNK_W;
    localparam int NCH   = (A_W + CW - 1) / CW;
    localparam int LO_W  = NCH * CW;
    localparam int PP_W  = CW + srpj_pkg::MAG_W;
    localparam int SUM_W = PP_W + 1;
    localparam int HI_W  = SUM_W - CW;
    localparam int P_W   = LO_W + HI_W;
    localparam int CNT_W = $clog2(NCH + 1);

    logic [LO_W-1:0]             r_a;
    logic [srpj_pkg::MAG_W-1:0]  r_b;
    logic [HI_W-1:0]             r_hi;
    logic [LO_W-1:0]             r_lo;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [PP_W-1:0]  s_pp;
    logic [SUM_W-1:0] s_sum;
    logic [P_W-1:0]   s_prod;

    assign s_pp   = PP_W'(r_a[CW-1:0]) * PP_W'(r_b);
    assign s_sum  = SUM_W'(r_hi) + SUM_W'(s_pp);
    assign s_prod = {r_hi, r_lo};

    assign o_stat.done = r_done;
    assign o_stat.sat  = |s_prod[P_W-1:srpj_pkg::SQ_IN_W];
    assign o_prod      = s_prod[srpj_pkg::SQ_IN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NCH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // low chunk first: finished bits shift into r_lo, carry part stays in r_hi
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= LO_W'(i_a);
            r_b  <= i_b;
            r_hi <= '0;
        end else if (r_busy) begin
            r_a  <= r_a >> CW;
            r_lo <= {s_sum[CW-1:0], r_lo[LO_W-1:CW]};
            r_hi <= s_sum[SUM_W-1:CW];
        end
    end

endmodule

/* sv/srpj_isqrt.sv */
// digit-by-digit floor square root, two radicand bits per cycle
// depends on srpj_pkg for the radicand and root widths
module srpj_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [srpj_pkg::SQ_IN_W-1:0]  i_n,
    output logic                          o_done,
    output logic [srpj_pkg::ROOT_W-1:0]   o_root
);
    localparam int RW    = srpj_pkg::ROOT_W;
    localparam int NW    = srpj_pkg::SQ_IN_W;
    localparam int REM_W = RW + 1;
    localparam int TRY_W = REM_W + 2;
    localparam int CNT_W = $clog2(RW + 1);

    logic [NW-1:0]    r_n;
    logic [REM_W-1:0] r_rem;
    logic [RW-1:0]    r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [TRY_W-1:0] s_rem2;
    logic [TRY_W-1:0] s_trial;
    logic [TRY_W-1:0] s_sub;
    logic             s_ge;

    assign s_rem2  = {r_rem, r_n[NW-1 -: 2]};
    assign s_trial = {1'b0, r_root, 2'b01};
    assign s_sub   = s_rem2 - s_trial;
    assign s_ge    = s_rem2 >= s_trial;

    assign o_done = r_done;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(RW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_n;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_n <= r_n << 2;
            if (s_ge) begin
                r_rem  <= s_sub[REM_W-1:0];
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= s_rem2[REM_W-1:0];
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

endmodule
